[src/nlsc_pkg.sv]
package nlsc_pkg;

   // Field widths of the channels and the configuration register.
   localparam int BYTE_WIDTH      = 8;
   localparam int LENGTH_WIDTH    = 40;
   localparam int FILE_SIZE_WIDTH = 40;
   localparam int UNIT_SIZE_WIDTH = 32;

   // Consumed-byte counter: COUNT_WIDTH plus one bit, saturating at all ones.
   localparam int COUNT_WIDTH = 40;
   localparam int CNT_WIDTH   = COUNT_WIDTH + 1;
   localparam logic [CNT_WIDTH-1:0] CNT_MAX = '1;

   // Width of the bounds and end-of-extent compares.
   localparam int SUM_WIDTH = (CNT_WIDTH + 1 > FILE_SIZE_WIDTH + 1) ?
                              CNT_WIDTH + 1 : FILE_SIZE_WIDTH + 1;

   // Size prefix is four bytes; index of its last byte.
   localparam logic [1:0] PREFIX_LAST = 2'd3;

   // Start code takes three beats; phase of its last byte.
   localparam logic [1:0] START_LAST_PHASE = 2'd2;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // File size after reset.
   localparam logic [FILE_SIZE_WIDTH-1:0] FILE_SIZE_RESET = '1;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]   data_byte;
      logic                    extent_start;
      logic [LENGTH_WIDTH-1:0] extent_length;
   } req_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] out_byte;
      logic                  is_error;
      logic                  extent_done;
      logic                  run_last;
   } rsp_type;

   // What the back has to emit for one accepted byte.
   typedef enum logic [1:0] {
      CMD_PAYLOAD,
      CMD_ERROR,
      CMD_START
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [BYTE_WIDTH-1:0] data;
      logic                  done;
   } cmd_type;

endpackage

[src/nal_length_to_start_code.sv]
// Converts a length-prefixed NAL unit byte stream into an Annex B stream.
// Input channel (req_): one extent byte per transfer; extent_start marks the
// first byte of an extent and carries extent_length with it.
// Result channel (rsp_): one output byte per transfer; run_last marks the last
// result of an input byte, extent_done the result that ends the extent, and
// is_error a unit running past file_size (sticky until reset).
// CSR port: csr_wr_en writes csr_wr_data into the file_size register;
// write it only while no results are outstanding.
// Path: each accepted byte's command is written into the command queue, and the
// back loads its result into the output register. Throughput: one input byte per
// clock while req_ready is high; the output side drains one result per clock
// while rsp_ready is high. The three start-code results of a unit follow its
// fourth size byte; the extra results back up at most three commands in the
// four-entry queue and drain while the next prefix arrives. The single output
// register sets the rate; a stalled receiver fills the queue, so req_ready drops.
// Reset (synchronous) empties the queue and output, sets file_size to all
// ones, clears the error and leaves the block idle until an extent start.
module nal_length_to_start_code (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  nlsc_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output nlsc_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [nlsc_pkg::FILE_SIZE_WIDTH-1:0]  csr_wr_data
);

   logic               push;
   nlsc_pkg::cmd_type  push_cmd;
   logic               full;
   logic               pop;
   logic               head_valid;
   nlsc_pkg::cmd_type  head_cmd;

   // Front: tracks prefixes and counts, classifies each byte.
   nlsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (full),
      .cmd_push    (push),
      .cmd         (push_cmd)
   );

   // Command queue decouples the two sides.
   nlsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Back: expands commands into result transfers.
   nlsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // An error result carries a zero byte, ends its run and never ends an extent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_error |->
         rsp_data.out_byte == '0 && rsp_data.run_last && !rsp_data.extent_done)
      else $error("error result has wrong fields");

   // The extent ends only on the last result of a byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.extent_done |-> rsp_data.run_last)
      else $error("extent_done without run_last");

   // After reset the output is empty and the block takes input.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

endmodule

[src/nlsc_queue.sv]
module nlsc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  nlsc_pkg::cmd_type  push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output nlsc_pkg::cmd_type  head_cmd
);

   nlsc_pkg::cmd_type                      entry_ff [nlsc_pkg::QUEUE_DEPTH];
   logic [nlsc_pkg::QPTR_WIDTH-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [nlsc_pkg::QPTR_WIDTH-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [nlsc_pkg::QCNT_WIDTH-1:0]        count_ff, count_in;
   logic                                   do_push;
   logic                                   do_pop;

   assign full       = (count_ff == nlsc_pkg::QCNT_WIDTH'(nlsc_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == nlsc_pkg::QPTR_WIDTH'(nlsc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == nlsc_pkg::QPTR_WIDTH'(nlsc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage is written on each push and is not reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[src/nlsc_front.sv]
module nlsc_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  nlsc_pkg::req_type                       req_data,
   input  logic                                    csr_wr_en,
   input  logic [nlsc_pkg::FILE_SIZE_WIDTH-1:0]    csr_wr_data,
   input  logic                                    queue_full,
   output logic                                    cmd_push,
   output nlsc_pkg::cmd_type                       cmd
);

   logic [1:0]                             prefix_index_ff, prefix_index_in;
   logic                                   in_payload_ff, in_payload_in;
   logic [nlsc_pkg::UNIT_SIZE_WIDTH-1:0]   size_accum_ff, size_accum_in;
   logic [nlsc_pkg::UNIT_SIZE_WIDTH-1:0]   payload_left_ff, payload_left_in;
   logic [nlsc_pkg::CNT_WIDTH-1:0]         consumed_ff, consumed_in;
   logic [nlsc_pkg::LENGTH_WIDTH-1:0]      target_ff, target_in;
   logic                                   halted_ff, halted_in;
   logic                                   err_ff, err_in;
   logic [nlsc_pkg::FILE_SIZE_WIDTH-1:0]   file_size_ff;
   logic                                   accept;
   logic [nlsc_pkg::SUM_WIDTH-1:0]         unit_sum;
   logic [nlsc_pkg::SUM_WIDTH-1:0]         unit_end_pos;
   logic [nlsc_pkg::SUM_WIDTH-1:0]         consumed_ext;
   logic [nlsc_pkg::SUM_WIDTH-1:0]         target_ext;
   logic                                   reached;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Walk one byte through the prefix and payload tracking, and classify it.
   always_comb begin
      prefix_index_in = prefix_index_ff;
      in_payload_in   = in_payload_ff;
      size_accum_in   = size_accum_ff;
      payload_left_in = payload_left_ff;
      consumed_in     = consumed_ff;
      target_in       = target_ff;
      halted_in       = halted_ff;
      err_in          = err_ff;
      cmd_push        = 1'b0;
      cmd.kind        = nlsc_pkg::CMD_PAYLOAD;
      cmd.data        = req_data.data_byte;
      cmd.done        = 1'b0;
      unit_sum        = '0;
      unit_end_pos    = '0;
      consumed_ext    = '0;
      target_ext      = '0;
      reached         = 1'b0;
      if (accept) begin
         if (err_ff) begin
            // Sticky error: every byte gives one error result.
            cmd_push = 1'b1;
            cmd.kind = nlsc_pkg::CMD_ERROR;
         end else begin
            if (req_data.extent_start) begin
               prefix_index_in = '0;
               in_payload_in   = 1'b0;
               size_accum_in   = '0;
               payload_left_in = '0;
               consumed_in     = '0;
               target_in       = req_data.extent_length;
               halted_in       = 1'b0;
            end
            if (!halted_in) begin
               consumed_in  = (consumed_in == nlsc_pkg::CNT_MAX) ?
                              consumed_in : consumed_in + 1'b1;
               consumed_ext = nlsc_pkg::SUM_WIDTH'(consumed_in);
               target_ext   = nlsc_pkg::SUM_WIDTH'(target_in);
               reached      = (consumed_ext >= target_ext);
               if (in_payload_in) begin
                  // Payload byte passes through; the last one may end the extent.
                  payload_left_in = payload_left_in - 1'b1;
                  cmd_push        = 1'b1;
                  cmd.kind        = nlsc_pkg::CMD_PAYLOAD;
                  if (payload_left_in == '0) begin
                     in_payload_in = 1'b0;
                     cmd.done      = reached;
                     halted_in     = reached;
                  end
               end else begin
                  size_accum_in = {size_accum_in[nlsc_pkg::UNIT_SIZE_WIDTH-9:0],
                                   req_data.data_byte};
                  if (prefix_index_in != nlsc_pkg::PREFIX_LAST) begin
                     prefix_index_in = prefix_index_in + 1'b1;
                  end else begin
                     // Prefix complete: bounds check against the file size.
                     unit_sum     = consumed_ext + nlsc_pkg::SUM_WIDTH'(size_accum_in);
                     unit_end_pos = (unit_sum > nlsc_pkg::SUM_WIDTH'(nlsc_pkg::CNT_MAX)) ?
                                    nlsc_pkg::SUM_WIDTH'(nlsc_pkg::CNT_MAX) : unit_sum;
                     cmd_push = 1'b1;
                     if (unit_end_pos > nlsc_pkg::SUM_WIDTH'(file_size_ff)) begin
                        err_in    = 1'b1;
                        halted_in = 1'b1;
                        cmd.kind  = nlsc_pkg::CMD_ERROR;
                     end else begin
                        cmd.kind        = nlsc_pkg::CMD_START;
                        prefix_index_in = '0;
                        if (size_accum_in == '0) begin
                           // Empty unit ends on the start code itself.
                           cmd.done  = reached;
                           halted_in = reached;
                        end else begin
                           payload_left_in = size_accum_in;
                           in_payload_in   = 1'b1;
                        end
                        size_accum_in = '0;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_index_ff <= '0;
         in_payload_ff   <= 1'b0;
         size_accum_ff   <= '0;
         payload_left_ff <= '0;
         consumed_ff     <= '0;
         target_ff       <= '0;
         halted_ff       <= 1'b1;
         err_ff          <= 1'b0;
      end else begin
         prefix_index_ff <= prefix_index_in;
         in_payload_ff   <= in_payload_in;
         size_accum_ff   <= size_accum_in;
         payload_left_ff <= payload_left_in;
         consumed_ff     <= consumed_in;
         target_ff       <= target_in;
         halted_ff       <= halted_in;
         err_ff          <= err_in;
      end
   end

   // File size register, written through the CSR port.
   always_ff @(posedge clock) begin
      if (reset) begin
         file_size_ff <= nlsc_pkg::FILE_SIZE_RESET;
      end else if (csr_wr_en) begin
         file_size_ff <= csr_wr_data;
      end
   end

endmodule

[src/nlsc_back.sv]
module nlsc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  nlsc_pkg::cmd_type  cmd,
   output logic               cmd_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output nlsc_pkg::rsp_type  rsp_data
);

   logic [1:0]         phase_ff, phase_in;
   logic               rsp_valid_ff, rsp_valid_in;
   nlsc_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   nlsc_pkg::rsp_type  beat;
   logic               load;
   logic               take;
   logic               last_beat;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Output register loads when empty or when its result is taken.
   assign load      = !rsp_valid_ff || rsp_ready;
   assign take      = cmd_valid && load;
   assign last_beat = (cmd.kind != nlsc_pkg::CMD_START) ||
                      (phase_ff == nlsc_pkg::START_LAST_PHASE);
   assign cmd_pop   = take && last_beat;

   // Expand the head command into its result for this beat.
   always_comb begin
      beat = '0;
      unique case (cmd.kind)
         nlsc_pkg::CMD_PAYLOAD: begin
            beat.out_byte    = cmd.data;
            beat.extent_done = cmd.done;
            beat.run_last    = 1'b1;
         end
         nlsc_pkg::CMD_ERROR: begin
            beat.is_error = 1'b1;
            beat.run_last = 1'b1;
         end
         nlsc_pkg::CMD_START: begin
            // Start code 00 00 01; the unit may end on its last byte.
            beat.out_byte    = nlsc_pkg::BYTE_WIDTH'(phase_ff == nlsc_pkg::START_LAST_PHASE);
            beat.extent_done = cmd.done && (phase_ff == nlsc_pkg::START_LAST_PHASE);
            beat.run_last    = (phase_ff == nlsc_pkg::START_LAST_PHASE);
         end
         default: begin
            beat = '0;
         end
      endcase
   end

   // Phase counter and output register next values.
   always_comb begin
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = cmd_valid;
         if (take) begin
            rsp_data_in = beat;
            phase_in    = last_beat ? 2'd0 : phase_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
